// ===== src/vci_pkg.sv =====
`default_nettype none

package vci_pkg;

  localparam int unsigned CountW   = 10;
  localparam int unsigned AccelW   = 16;
  localparam int unsigned SquareW  = 2 * AccelW - 1;
  localparam int unsigned ThreshW  = 33;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned SecondsW = 8;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = ThreshW;

  // Reset values of the configuration registers and the countdown
  localparam logic [CountW-1:0]   TempLimitRst   = 10'd174;
  localparam logic [CountW-1:0]   LoadLimitRst   = 10'd800;
  localparam logic [CountW-1:0]   PressureMinRst = 10'd300;
  localparam logic [ThreshW-1:0]  ImpactSqRst    = 33'd5435817984;
  localparam logic [SecondsW-1:0] CountdownRst   = 8'd60;
  localparam logic [TicksW-1:0]   AuthRetryRst   = 16'd10000;
  localparam logic [TicksW-1:0]   SecondTicksRst = 16'd1000;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_ID_OK    = 3'd1,
    ACT_ID_FAIL  = 3'd2,
    ACT_PHONE_OK = 3'd3,
    ACT_PHONE_LOST = 3'd4,
    ACT_DIAG     = 3'd5,
    ACT_ACCEL    = 3'd6
  } act_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_LIMIT   = 3'd0,
    CFG_LOAD_LIMIT   = 3'd1,
    CFG_PRESSURE_MIN = 3'd2,
    CFG_IMPACT_SQ    = 3'd3,
    CFG_COUNTDOWN    = 3'd4,
    CFG_AUTH_RETRY   = 3'd5,
    CFG_SECOND_TICKS = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OVERHEAT = 2'd1,
    FAULT_OVERLOAD = 2'd2,
    FAULT_PRESSURE = 2'd3
  } fault_t;

  typedef struct packed {
    logic [CountW-1:0]   temp_limit_raw;
    logic [CountW-1:0]   load_max;
    logic [CountW-1:0]   pressure_min;
    logic [ThreshW-1:0]  impact_threshold_sq;
    logic [SecondsW-1:0] countdown_start;
    logic [TicksW-1:0]   auth_retry_ms;
    logic [TicksW-1:0]   second_ticks;
  } cfg_t;

  // One registered input item, with the squares already formed
  typedef struct packed {
    act_t               action;
    logic [CountW-1:0]  pressure;
    logic [CountW-1:0]  load;
    logic [CountW-1:0]  temp_raw;
    logic [SquareW-1:0] sq_x;
    logic [SquareW-1:0] sq_y;
    logic [SquareW-1:0] sq_z;
  } item_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic                relay_on;
    logic                request_auth;
    fault_t              diag_fault;
    logic                phone_warning;
    logic [SecondsW-1:0] seconds_left;
    logic                dispatch;
  } result_t;

endpackage

`default_nettype wire

// ===== src/vci_cfg_regs.sv =====
`default_nettype none

module vci_cfg_regs
  import vci_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_limit_raw      <= TempLimitRst;
      cfg_r.load_max            <= LoadLimitRst;
      cfg_r.pressure_min        <= PressureMinRst;
      cfg_r.impact_threshold_sq <= ImpactSqRst;
      cfg_r.countdown_start     <= CountdownRst;
      cfg_r.auth_retry_ms       <= AuthRetryRst;
      cfg_r.second_ticks        <= SecondTicksRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_LIMIT:   cfg_r.temp_limit_raw      <= cfg_wdata[CountW-1:0];
        CFG_LOAD_LIMIT:   cfg_r.load_max            <= cfg_wdata[CountW-1:0];
        CFG_PRESSURE_MIN: cfg_r.pressure_min        <= cfg_wdata[CountW-1:0];
        CFG_IMPACT_SQ:    cfg_r.impact_threshold_sq <= cfg_wdata[ThreshW-1:0];
        CFG_COUNTDOWN:    cfg_r.countdown_start     <= cfg_wdata[SecondsW-1:0];
        CFG_AUTH_RETRY:   cfg_r.auth_retry_ms       <= cfg_wdata[TicksW-1:0];
        CFG_SECOND_TICKS: cfg_r.second_ticks        <= cfg_wdata[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== src/vci_in_stage.sv =====
`default_nettype none

module vci_in_stage
  import vci_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [InDataW-1:0] in_tdata,
  input  wire logic [InUserW-1:0] in_tuser,
  input  wire logic               advance,
  output logic                    item_valid,
  output item_t                   item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic signed [2*AccelW-1:0] prod_x, prod_y, prod_z;

  assign prod_x = $signed(in_tdata[45:30]) * $signed(in_tdata[45:30]);
  assign prod_y = $signed(in_tdata[61:46]) * $signed(in_tdata[61:46]);
  assign prod_z = $signed(in_tdata[77:62]) * $signed(in_tdata[77:62]);

  always_comb begin
    item_nxt.action   = act_t'(in_tuser);
    item_nxt.pressure = in_tdata[9:0];
    item_nxt.load     = in_tdata[19:10];
    item_nxt.temp_raw = in_tdata[29:20];
    item_nxt.sq_x     = prod_x[SquareW-1:0];
    item_nxt.sq_y     = prod_y[SquareW-1:0];
    item_nxt.sq_z     = prod_z[SquareW-1:0];
  end

  // Take a new transaction whenever the register is empty or the held one leaves this cycle
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== src/vci_core.sv =====
`default_nettype none

module vci_core
  import vci_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       advance,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    result
);

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'd0,
    MODE_DIAG  = 3'd1,
    MODE_TRAN  = 3'd2,
    MODE_CRASH = 3'd3,
    MODE_HALT  = 3'd4
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic                identity_ok_r, identity_ok_nxt;
  logic                phone_ok_r, phone_ok_nxt;
  logic [TicksW-1:0]   retry_elapsed_r, retry_elapsed_nxt;
  logic [TicksW-1:0]   second_elapsed_r, second_elapsed_nxt;
  logic [SecondsW-1:0] countdown_r, countdown_nxt;
  logic                relay_r, relay_nxt;
  logic                out_valid_r;
  result_t             result_r, result_nxt;

  logic                req, warn, disp;
  fault_t              fault;
  logic [TicksW-1:0]   sec_inc;
  logic [SecondsW-1:0] cd_dec;
  logic [ThreshW-1:0]  mag_sq;
  logic                take;

  assign advance = !out_valid_r || out_ready;
  assign take    = item_valid && advance;

  assign mag_sq = {2'b00, item.sq_x} + {2'b00, item.sq_y} + {2'b00, item.sq_z};
  assign sec_inc = (second_elapsed_r == {TicksW{1'b1}}) ? second_elapsed_r
                                                        : second_elapsed_r + 1'b1;
  assign cd_dec = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;

  always_comb begin
    mode_nxt           = mode_r;
    identity_ok_nxt    = identity_ok_r;
    phone_ok_nxt       = phone_ok_r;
    retry_elapsed_nxt  = retry_elapsed_r;
    second_elapsed_nxt = second_elapsed_r;
    countdown_nxt      = countdown_r;
    relay_nxt          = relay_r;
    req   = 1'b0;
    warn  = 1'b0;
    disp  = 1'b0;
    fault = FAULT_NONE;

    if (mode_r != MODE_HALT) begin
      case (item.action)
        ACT_TICK: begin
          if (mode_r == MODE_WAIT) begin
            if (retry_elapsed_r >= cfg.auth_retry_ms) begin
              req               = 1'b1;
              retry_elapsed_nxt = '0;
            end else begin
              retry_elapsed_nxt = retry_elapsed_r + 1'b1;
            end
          end else if (mode_r == MODE_CRASH) begin
            if (sec_inc >= cfg.second_ticks) begin
              second_elapsed_nxt = '0;
              countdown_nxt      = cd_dec;
              if (cd_dec == '0) begin
                disp      = 1'b1;
                relay_nxt = 1'b0;
                mode_nxt  = MODE_HALT;
              end
            end else begin
              second_elapsed_nxt = sec_inc;
            end
          end
        end
        ACT_ID_OK:    identity_ok_nxt = 1'b1;
        ACT_ID_FAIL:  identity_ok_nxt = 1'b0;
        ACT_PHONE_OK: phone_ok_nxt    = 1'b1;
        ACT_PHONE_LOST: begin
          phone_ok_nxt = 1'b0;
          warn         = (mode_r == MODE_TRAN);
        end
        ACT_DIAG: begin
          if (mode_r == MODE_DIAG) begin
            if (item.temp_raw > cfg.temp_limit_raw) begin
              fault = FAULT_OVERHEAT;
            end else if (item.load > cfg.load_max) begin
              fault = FAULT_OVERLOAD;
            end else if (item.pressure < cfg.pressure_min) begin
              fault = FAULT_PRESSURE;
            end else begin
              relay_nxt = 1'b1;
              mode_nxt  = MODE_TRAN;
            end
          end
        end
        ACT_ACCEL: begin
          if (mode_r == MODE_TRAN && mag_sq >= cfg.impact_threshold_sq) begin
            relay_nxt          = 1'b0;
            countdown_nxt      = cfg.countdown_start;
            second_elapsed_nxt = '0;
            mode_nxt           = MODE_CRASH;
          end
        end
        default: ;
      endcase
      if (mode_nxt == MODE_WAIT && identity_ok_nxt && phone_ok_nxt) begin
        mode_nxt = MODE_DIAG;
      end
    end

    result_nxt.mode          = mode_nxt;
    result_nxt.relay_on      = relay_nxt;
    result_nxt.request_auth  = req;
    result_nxt.diag_fault    = fault;
    result_nxt.phone_warning = warn;
    result_nxt.seconds_left  = countdown_nxt;
    result_nxt.dispatch      = disp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_WAIT;
      identity_ok_r    <= 1'b0;
      phone_ok_r       <= 1'b0;
      retry_elapsed_r  <= '0;
      second_elapsed_r <= '0;
      countdown_r      <= CountdownRst;
      relay_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (take) begin
        mode_r           <= mode_nxt;
        identity_ok_r    <= identity_ok_nxt;
        phone_ok_r       <= phone_ok_nxt;
        retry_elapsed_r  <= retry_elapsed_nxt;
        second_elapsed_r <= second_elapsed_nxt;
        countdown_r      <= countdown_nxt;
        relay_r          <= relay_nxt;
      end
      if (advance) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

`default_nettype wire

// ===== src/vehicle_crash_interlock_fsm.sv =====
// Start and crash interlock: one result transaction for every input transaction, in order.
// An item is held in the input register, is decoded there against the held mode and
// counters, and its result lands in the output register; one item is taken every cycle
// while the result side keeps up, and the rate is set by the single decode step between
// those two registers, which also updates the state. The three accelerometer squares
// are formed as an item enters and are held in the input register, leaving one add and
// compare for the crash check. Configuration writes take effect at once and must be
// made while no item is in flight.
`default_nettype none

module vehicle_crash_interlock_fsm
  import vci_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Input transactions
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // pressure[9:0], load[19:10], temp_raw[29:20], accel_x[45:30],
  // accel_y[61:46], accel_z[77:62], zero pad[79:78]
  input  wire logic [InDataW-1:0]  in_tdata,
  // action[2:0]
  input  wire logic [InUserW-1:0]  in_tuser,
  // Result transactions
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // mode[2:0], relay_on[3], request_auth[4], diag_fault[6:5],
  // phone_warning[7], seconds_left[15:8], dispatch[16], zero pad[23:17]
  output logic [OutDataW-1:0]      out_tdata,
  // Configuration writes
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item;
  result_t result;
  logic    item_valid;
  logic    advance;

  // Limits, threshold and timing registers
  vci_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Hold the accepted transaction and its squared accelerations
  vci_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Decode the held item, advance the interlock state and register the result
  vci_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  // Pack the result, mode in the lowest bits, pad to whole bytes
  assign out_tdata = {{(OutDataW - $bits(result_t)){1'b0}},
                      result.dispatch,
                      result.seconds_left,
                      result.phone_warning,
                      result.diag_fault,
                      result.request_auth,
                      result.relay_on,
                      result.mode};

endmodule

`default_nettype wire
